>>> rtl/tap_pressure_envelope_defines.svh
// Assertion macros for the tap pressure envelope block.
// Included by the RTL files that carry concurrent checks; no other dependency.
`ifndef TAP_PRESSURE_ENVELOPE_DEFINES_SVH
`define TAP_PRESSURE_ENVELOPE_DEFINES_SVH
`ifndef SYNTHESIS
`define TPE_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("tpe: same-cycle check failed");
`define TPE_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("tpe: next-cycle check failed");
`else
`define TPE_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define TPE_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

>>> rtl/tpe_pkg.sv
// Shared types, constants, clamp helpers and the quarter-wave sine table
// of the tap pressure envelope. No dependencies.
package tpe_pkg;

  localparam int TIME_BITS   = 24;
  localparam int SINE_DEPTH  = 256;
  localparam int SINE_IDX_W  = $clog2(SINE_DEPTH);
  localparam int POS_W       = SINE_IDX_W + 2;
  localparam int LEN_W       = 20;
  localparam int PEAK_W      = 17;
  localparam int DEPTH_W     = 16;
  localparam int RATE_W      = 16;
  localparam int X_W         = 16;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_IDX_W   = 3;
  localparam int FULL_SCALE  = 65536;
  localparam int MIN_LEN     = 1000;
  localparam int MIN_RATE    = 10;
  localparam int RATE_PERIOD = 100000000;
  localparam int BASE_W      = 27;
  localparam int PHASE_W     = RATE_W + LEN_W;
  localparam int REM_W       = PHASE_W + POS_W;
  // whole periods of the tremor phase stay below 2^10
  localparam int HOLD_QBITS  = 10;
  localparam int NSTEP       = (HOLD_QBITS + POS_W > X_W) ? HOLD_QBITS + POS_W : X_W;
  localparam int CMP_W       = BASE_W + NSTEP;
  localparam int DIFF_W      = ((TIME_BITS > LEN_W + 2) ? TIME_BITS : LEN_W + 2) + 2;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam longint Q30     = 64'sd1073741824;

  typedef enum logic [2:0] {
    SEG_PRE  = 3'd0,
    SEG_RISE = 3'd1,
    SEG_HOLD = 3'd2,
    SEG_FALL = 3'd3,
    SEG_DONE = 3'd4
  } seg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ONSET = 3'd0,
    CFG_RISE  = 3'd1,
    CFG_HOLD  = 3'd2,
    CFG_FALL  = 3'd3,
    CFG_PEAK  = 3'd4,
    CFG_DEPTH = 3'd5,
    CFG_RATE  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [LEN_W-1:0]   onset;
    logic [LEN_W-1:0]   rise;
    logic [LEN_W-1:0]   hold;
    logic [LEN_W-1:0]   fall;
    logic [PEAK_W-1:0]  peak;
    logic [DEPTH_W-1:0] depth;
    logic [RATE_W-1:0]  rate;
  } cfg_t;

  typedef struct packed {
    seg_t             seg;
    logic [LEN_W-1:0] d;
    logic [LEN_W-1:0] len;
  } q_item_t;

  typedef struct packed {
    logic [PEAK_W-1:0] pressure;
    seg_t              seg;
  } res_t;

  typedef logic [PEAK_W-1:0] sine_tab_t [0:SINE_DEPTH];

  function automatic logic [LEN_W-1:0] len_eff(input logic [LEN_W-1:0] v);
    return (v < LEN_W'(MIN_LEN)) ? LEN_W'(MIN_LEN) : v;
  endfunction

  function automatic logic [RATE_W-1:0] rate_eff(input logic [RATE_W-1:0] v);
    return (v < RATE_W'(MIN_RATE)) ? RATE_W'(MIN_RATE) : v;
  endfunction

  function automatic logic [PEAK_W-1:0] peak_eff(input logic [PEAK_W-1:0] v);
    return (v > PEAK_W'(FULL_SCALE)) ? PEAK_W'(FULL_SCALE) : v;
  endfunction

  // degree-9 odd Taylor series in Q2.30, Horner form, rounded to Q1.16
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t t;
    longint u;
    longint u2;
    longint p;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      u  = (longint'(i) * Q30) / SINE_DEPTH;
      u2 = (u * u) / Q30;
      p  = 64'sd172271;
      p  = -64'sd5026995 + (p * u2) / Q30;
      p  = 64'sd85569306 + (p * u2) / Q30;
      p  = -64'sd693598668 + (p * u2) / Q30;
      p  = 64'sd1686629713 + (p * u2) / Q30;
      p  = (p * u) / Q30;
      p  = (p + 64'sd8192) / 64'sd16384;
      if (p < 0) p = 0;
      if (p > FULL_SCALE) p = FULL_SCALE;
      t[i] = p[PEAK_W-1:0];
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

>>> rtl/tpe_front.sv
// Front end: takes time stamps, locates the envelope segment and the time
// into it, and hands a classified word to the queue. Depends on tpe_pkg.
module tpe_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tpe_pkg::cfg_t                  cfg,
  input  logic                           push,
  input  logic [tpe_pkg::TIME_BITS-1:0]  elapsed_time,
  output logic                           full,
  output logic                           q_push,
  output tpe_pkg::q_item_t               q_item,
  input  logic                           q_full
);
  import tpe_pkg::*;

  logic              en_f;
  logic              f1_v_r;
  logic [DIFF_W-1:0] f1_d0_r;
  logic [DIFF_W-1:0] f1_d1_r;
  logic [DIFF_W-1:0] d0_nxt;
  logic [DIFF_W-1:0] d1_nxt;
  logic [DIFF_W-1:0] d2;
  logic [DIFF_W-1:0] d3;
  logic              f2_v_r;
  q_item_t           f2_item_r;
  q_item_t           item_nxt;
  logic [LEN_W-1:0]  rise_l;
  logic [LEN_W-1:0]  hold_l;
  logic [LEN_W-1:0]  fall_l;

  assign rise_l = len_eff(cfg.rise);
  assign hold_l = len_eff(cfg.hold);
  assign fall_l = len_eff(cfg.fall);

  assign en_f   = !f2_v_r || !q_full;
  assign full   = !en_f;
  assign q_push = f2_v_r && !q_full;
  assign q_item = f2_item_r;

  // negative differences flag that the time lies before a boundary
  always_comb begin
    d0_nxt = DIFF_W'(elapsed_time) - DIFF_W'(cfg.onset);
    d1_nxt = d0_nxt - DIFF_W'(rise_l);
    d2     = f1_d1_r - DIFF_W'(hold_l);
    d3     = d2 - DIFF_W'(fall_l);
    item_nxt.seg = SEG_DONE;
    item_nxt.d   = '0;
    item_nxt.len = rise_l;
    if (f1_d0_r[DIFF_W-1]) begin
      item_nxt.seg = SEG_PRE;
    end else if (f1_d1_r[DIFF_W-1]) begin
      item_nxt.seg = SEG_RISE;
      item_nxt.d   = f1_d0_r[LEN_W-1:0];
    end else if (d2[DIFF_W-1]) begin
      item_nxt.seg = SEG_HOLD;
      item_nxt.d   = f1_d1_r[LEN_W-1:0];
    end else if (d3[DIFF_W-1]) begin
      item_nxt.seg = SEG_FALL;
      item_nxt.d   = d2[LEN_W-1:0];
      item_nxt.len = fall_l;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (en_f) begin
      f1_v_r <= push;
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      f1_d0_r   <= d0_nxt;
      f1_d1_r   <= d1_nxt;
      f2_item_r <= item_nxt;
    end
  end

endmodule

>>> rtl/tpe_queue.sv
// Short queue of classified words between the front and back ends.
// Depends on tpe_pkg.
module tpe_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tpe_pkg::q_item_t item_in,
  output logic             full,
  input  logic             pop,
  output tpe_pkg::q_item_t item_out,
  output logic             empty
);
  import tpe_pkg::*;

  q_item_t           mem_r [0:QDEPTH-1];
  logic [QPTR_W-1:0] wr_r;
  logic [QPTR_W-1:0] rd_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full     = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign item_out = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop) rd_r <= rd_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= item_in;
  end

endmodule

>>> rtl/tpe_back.sv
// Back end: shared restoring divider stages (smoothstep ratio or tremor
// phase), sine lookup, shaping multipliers and the result buffer.
// Depends on tpe_pkg and tap_pressure_envelope_defines.svh.
`include "tap_pressure_envelope_defines.svh"
module tpe_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tpe_pkg::cfg_t              cfg,
  input  tpe_pkg::q_item_t           q_item,
  input  logic                       q_empty,
  output logic                       q_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic [tpe_pkg::PEAK_W-1:0] pressure,
  output logic [2:0]                 segment
);
  import tpe_pkg::*;

  logic                en_b;
  logic [REM_W-1:0]    st_rem_r  [0:NSTEP-1];
  logic [BASE_W-1:0]   st_base_r [0:NSTEP-1];
  logic [NSTEP-1:0]    st_q_r    [1:NSTEP];
  seg_t                st_seg_r  [0:NSTEP];
  logic                st_v_r    [0:NSTEP];
  logic [NSTEP-1:0]    q_in      [0:NSTEP-1];
  logic [CMP_W-1:0]    den       [0:NSTEP-1];
  logic [CMP_W-1:0]    diff      [0:NSTEP-1];
  logic                ge        [0:NSTEP-1];

  logic [REM_W-1:0]    rem0_nxt;
  logic [BASE_W-1:0]   base0_nxt;
  logic [PHASE_W-1:0]  phase;

  logic [X_W-1:0]        x;
  logic [POS_W-1:0]      pos;
  logic [SINE_IDX_W:0]   sidx;
  logic                  t1_v_r;
  seg_t                  t1_seg_r;
  logic [2*X_W-1:0]      t1_sq_r;
  logic [X_W-1:0]        t1_x_r;
  logic [PEAK_W-1:0]     t1_sin_r;
  logic                  t1_neg_r;

  logic [X_W+1:0]        wt;
  logic [3*X_W+1:0]      sm;
  logic [DEPTH_W+PEAK_W-1:0] tm;
  logic                  t2_v_r;
  seg_t                  t2_seg_r;
  logic [X_W-1:0]        t2_s_r;
  logic [PEAK_W:0]       t2_trem_r;

  logic [PEAK_W:0]       factor;
  logic                  t3_v_r;
  seg_t                  t3_seg_r;
  logic [2*PEAK_W:0]     t3_prod_r;
  logic [PEAK_W+1:0]     p_full;

  res_t                  ob_r [0:1];
  logic                  ob_wr_r;
  logic                  ob_rd_r;
  logic [1:0]            ob_cnt_r;
  logic                  ob_full;
  logic                  ob_push;
  logic                  ob_pop;
  res_t                  res_nxt;

  assign ob_full = (ob_cnt_r == 2'd2);
  assign en_b    = !t3_v_r || !ob_full;
  assign ob_push = t3_v_r && !ob_full;
  assign ob_pop  = pop && (ob_cnt_r != 2'd0);
  assign q_pop   = en_b && !q_empty;

  // load: rise and fall divide d*2^16 by the length, hold divides the
  // scaled phase by the tremor period
  always_comb begin
    phase     = PHASE_W'(rate_eff(cfg.rate)) * PHASE_W'(q_item.d);
    rem0_nxt  = '0;
    base0_nxt = BASE_W'(RATE_PERIOD);
    case (q_item.seg)
      SEG_RISE, SEG_FALL: begin
        rem0_nxt  = REM_W'({q_item.d, {X_W{1'b0}}});
        base0_nxt = BASE_W'(q_item.len);
      end
      SEG_HOLD: rem0_nxt = REM_W'(phase) << POS_W;
      default: ;
    endcase
  end

  // one quotient bit per stage against a shrinking shifted divisor
  always_comb begin
    for (int k = 0; k < NSTEP; k++) begin
      q_in[k] = (k == 0) ? '0 : st_q_r[(k == 0) ? 1 : k];
      den[k]  = CMP_W'(st_base_r[k]) << (NSTEP - 1 - k);
      diff[k] = CMP_W'(st_rem_r[k]) - den[k];
      ge[k]   = (CMP_W'(st_rem_r[k]) >= den[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NSTEP; k++) st_v_r[k] <= 1'b0;
      t1_v_r <= 1'b0;
      t2_v_r <= 1'b0;
      t3_v_r <= 1'b0;
    end else if (en_b) begin
      st_v_r[0] <= !q_empty;
      for (int k = 0; k < NSTEP; k++) st_v_r[k+1] <= st_v_r[k];
      t1_v_r <= st_v_r[NSTEP];
      t2_v_r <= t1_v_r;
      t3_v_r <= t2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      st_rem_r[0]  <= rem0_nxt;
      st_base_r[0] <= base0_nxt;
      st_seg_r[0]  <= q_item.seg;
      for (int k = 0; k < NSTEP; k++) begin
        st_q_r[k+1]   <= {q_in[k][NSTEP-2:0], ge[k]};
        st_seg_r[k+1] <= st_seg_r[k];
        if (k < NSTEP - 1) begin
          st_rem_r[k+1]  <= ge[k] ? diff[k][REM_W-1:0] : st_rem_r[k];
          st_base_r[k+1] <= st_base_r[k];
        end
      end
    end
  end

  // square the ratio; fold the phase into the quarter-wave table
  always_comb begin
    x    = st_q_r[NSTEP][X_W-1:0];
    pos  = st_q_r[NSTEP][POS_W-1:0];
    sidx = pos[POS_W-2] ? ((SINE_IDX_W+1)'(SINE_DEPTH) - {1'b0, pos[SINE_IDX_W-1:0]})
                        : {1'b0, pos[SINE_IDX_W-1:0]};
  end

  always_comb begin
    wt = (X_W+2)'(3 * FULL_SCALE) - {1'b0, t1_x_r, 1'b0};
    sm = (3*X_W+2)'(t1_sq_r) * (3*X_W+2)'(wt);
    tm = (DEPTH_W+PEAK_W)'(cfg.depth) * (DEPTH_W+PEAK_W)'(t1_sin_r);
  end

  always_comb begin
    case (t2_seg_r)
      SEG_RISE: factor = (PEAK_W+1)'(t2_s_r);
      SEG_FALL: factor = (PEAK_W+1)'(FULL_SCALE) - (PEAK_W+1)'(t2_s_r);
      SEG_HOLD: factor = t2_trem_r;
      default:  factor = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      t1_seg_r  <= st_seg_r[NSTEP];
      t1_sq_r   <= (2*X_W)'(x) * (2*X_W)'(x);
      t1_x_r    <= x;
      t1_sin_r  <= SINE_TAB[sidx];
      t1_neg_r  <= pos[POS_W-1];
      t2_seg_r  <= t1_seg_r;
      t2_s_r    <= sm[4*X_W-1-X_W:2*X_W];
      // truncate toward zero: scale the magnitude, then apply the sign
      t2_trem_r <= t1_neg_r ? (PEAK_W+1)'(FULL_SCALE) - (PEAK_W+1)'(tm[DEPTH_W+15:16])
                            : (PEAK_W+1)'(FULL_SCALE) + (PEAK_W+1)'(tm[DEPTH_W+15:16]);
      t3_seg_r  <= t2_seg_r;
      t3_prod_r <= (2*PEAK_W+1)'(peak_eff(cfg.peak)) * (2*PEAK_W+1)'(factor);
    end
  end

  // saturate to full scale
  always_comb begin
    p_full           = t3_prod_r[2*PEAK_W:16];
    res_nxt.pressure = (p_full > (PEAK_W+2)'(FULL_SCALE)) ? PEAK_W'(FULL_SCALE)
                                                           : p_full[PEAK_W-1:0];
    res_nxt.seg      = t3_seg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wr_r  <= 1'b0;
      ob_rd_r  <= 1'b0;
      ob_cnt_r <= 2'd0;
    end else begin
      if (ob_push) ob_wr_r <= !ob_wr_r;
      if (ob_pop) ob_rd_r <= !ob_rd_r;
      if (ob_push && !ob_pop) ob_cnt_r <= ob_cnt_r + 2'd1;
      else if (ob_pop && !ob_push) ob_cnt_r <= ob_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ob_push) ob_r[ob_wr_r] <= res_nxt;
  end

  assign empty    = (ob_cnt_r == 2'd0);
  assign pressure = ob_r[ob_rd_r].pressure;
  assign segment  = ob_r[ob_rd_r].seg;

  `TPE_ASSERT_IMP(a_ob_bound, clk, rst_n, 1'b1, ob_cnt_r <= 2'd2)
  `TPE_ASSERT_NXT(a_tail_hold, clk, rst_n, t3_v_r && ob_full, t3_v_r && $stable(t3_prod_r))
  `TPE_ASSERT_NXT(a_ob_drain, clk, rst_n, ob_pop && !ob_push, ob_cnt_r == $past(ob_cnt_r) - 2'd1)
  `TPE_ASSERT_IMP(a_no_pop_empty, clk, rst_n, q_pop, !q_empty && en_b)

endmodule

>>> rtl/tap_pressure_envelope.sv
// Top level: configuration registers, front end, word queue, back end.
// Depends on tpe_pkg, tpe_front, tpe_queue and tpe_back.
// Throughput: one time stamp per cycle, sustained while results are popped.
// Path from push to result: front registers f1 and f2, the word queue,
// the one-bit restoring divider stages, t1 to t3 and the result buffer.
// Reset: synchronous, active low; registers return to their defaults,
// queue and result buffer empty, no clearing pass.
module tap_pressure_envelope (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [tpe_pkg::TIME_BITS-1:0]   in_elapsed_time,
  output logic                            empty,
  input  logic                            pop,
  output logic [tpe_pkg::PEAK_W-1:0]      out_pressure,
  output logic [2:0]                      out_segment,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tpe_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tpe_pkg::*;

  cfg_t    cfg_r;
  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  q_item_t q_wr_item;
  q_item_t q_rd_item;

  assign cfg_ready = 1'b1;

  // writes to unlisted indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.onset <= '0;
      cfg_r.rise  <= LEN_W'(MIN_LEN);
      cfg_r.hold  <= LEN_W'(MIN_LEN);
      cfg_r.fall  <= LEN_W'(MIN_LEN);
      cfg_r.peak  <= PEAK_W'(FULL_SCALE);
      cfg_r.depth <= '0;
      cfg_r.rate  <= RATE_W'(1000);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ONSET: cfg_r.onset <= cfg_data[LEN_W-1:0];
        CFG_RISE:  cfg_r.rise  <= cfg_data[LEN_W-1:0];
        CFG_HOLD:  cfg_r.hold  <= cfg_data[LEN_W-1:0];
        CFG_FALL:  cfg_r.fall  <= cfg_data[LEN_W-1:0];
        CFG_PEAK:  cfg_r.peak  <= cfg_data[PEAK_W-1:0];
        CFG_DEPTH: cfg_r.depth <= cfg_data[DEPTH_W-1:0];
        CFG_RATE:  cfg_r.rate  <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  tpe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .push         (push),
    .elapsed_time (in_elapsed_time),
    .full         (full),
    .q_push       (q_push),
    .q_item       (q_wr_item),
    .q_full       (q_full)
  );

  tpe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .item_in  (q_wr_item),
    .full     (q_full),
    .pop      (q_pop),
    .item_out (q_rd_item),
    .empty    (q_empty)
  );

  tpe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_item   (q_rd_item),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .pressure (out_pressure),
    .segment  (out_segment)
  );

endmodule

>>> sim/tb.sv
// Self-checking bench for tap_pressure_envelope: directed table, then random phases.
// Depends on tpe_pkg for widths, segment and register codes; needs only the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tpe_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int FLOOD_HOLD   = 300;

  logic                  clk;
  logic                  rst_n;
  logic                  push;
  logic                  full;
  logic [TIME_BITS-1:0]  in_elapsed_time;
  logic                  empty;
  logic                  pop;
  logic [PEAK_W-1:0]     out_pressure;
  logic [2:0]            out_segment;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tap_pressure_envelope dut (.*);

  typedef struct {
    logic [PEAK_W-1:0] pressure;
    seg_t              seg;
  } level_t;

  // register copies for the envelope model
  longint unsigned m_onset, m_rise, m_hold, m_fall, m_peak, m_depth, m_rate;
  longint          qsine [0:SINE_DEPTH];
  level_t          level_q [$];
  int              errors = 0;
  bit              tx_calm, rx_calm, rx_hold;
  int              rx_wait = 0;
  // typed-in expectation that rides along with the current word
  bit              row_known;
  level_t          row_level;

  initial begin
    clk = 1'b0;
    forever begin
      #4 clk = 1'b1;
      #4 clk = 1'b0;
    end
  end

  function automatic longint taylor_sine(longint a);
    longint one, a2, acc;
    one = 64'sd1073741824;
    a2  = (a * a) / one;
    acc = 64'sd172271;
    acc = -64'sd5026995 + (acc * a2) / one;
    acc = 64'sd85569306 + (acc * a2) / one;
    acc = -64'sd693598668 + (acc * a2) / one;
    acc = 64'sd1686629713 + (acc * a2) / one;
    acc = (acc * a) / one;
    acc = (acc + 8192) / 16384;
    if (acc < 0) acc = 0;
    if (acc > FULL_SCALE) acc = FULL_SCALE;
    return acc;
  endfunction

  function automatic longint unsigned ease(longint unsigned d, longint unsigned len);
    longint unsigned x;
    x = (d * FULL_SCALE) / len;
    if (x > FULL_SCALE) x = FULL_SCALE;
    return (x * x * (3 * FULL_SCALE - 2 * x)) >> 32;
  endfunction

  function automatic level_t envelope_level(logic [TIME_BITS-1:0] et);
    level_t r;
    longint unsigned e, rl, hl, fl, rt, pk, t_rise, t_hold, t_fall, ph, pos, quad, ix, lvl;
    longint s, trem;
    e   = et;
    rl  = (m_rise < MIN_LEN) ? MIN_LEN : m_rise;
    hl  = (m_hold < MIN_LEN) ? MIN_LEN : m_hold;
    fl  = (m_fall < MIN_LEN) ? MIN_LEN : m_fall;
    rt  = (m_rate < MIN_RATE) ? MIN_RATE : m_rate;
    pk  = (m_peak > FULL_SCALE) ? FULL_SCALE : m_peak;
    t_rise = m_onset + rl;
    t_hold = t_rise + hl;
    t_fall = t_hold + fl;
    lvl = 0;
    if (e < m_onset) begin
      r.seg = SEG_PRE;
    end else if (e < t_rise) begin
      r.seg = SEG_RISE;
      lvl = (pk * ease(e - m_onset, rl)) >> 16;
    end else if (e < t_hold) begin
      r.seg = SEG_HOLD;
      ph   = (rt * (e - t_rise)) % RATE_PERIOD;
      pos  = (ph * (4 * SINE_DEPTH)) / RATE_PERIOD;
      quad = (pos / SINE_DEPTH) & 3;
      ix   = pos % SINE_DEPTH;
      s    = quad[0] ? qsine[SINE_DEPTH - ix] : qsine[ix];
      if (quad[1]) s = -s;
      trem = longint'(FULL_SCALE) + (longint'(m_depth) * s) / longint'(FULL_SCALE);
      if (trem < 0) trem = 0;
      lvl = (pk * longint'(trem)) >> 16;
    end else if (e < t_fall) begin
      r.seg = SEG_FALL;
      lvl = (pk * (FULL_SCALE - ease(e - t_hold, fl))) >> 16;
    end else begin
      r.seg = SEG_DONE;
    end
    if (lvl > FULL_SCALE) lvl = FULL_SCALE;
    r.pressure = lvl[PEAK_W-1:0];
    return r;
  endfunction

  // predict on every accepted word, check every popped word
  always @(posedge clk) begin
    level_t got, want;
    if (rst_n) begin
      if (push && !full)
        level_q.push_back(row_known ? row_level : envelope_level(in_elapsed_time));
      if (pop && !empty) begin
        got.pressure = out_pressure;
        got.seg      = seg_t'(out_segment);
        if (level_q.size() == 0) begin
          $display("%0t: unexpected word pressure=%0d segment=%0d", $time,
                   out_pressure, out_segment);
          errors++;
        end else begin
          want = level_q.pop_front();
          if (got.pressure !== want.pressure) begin
            $display("%0t: pressure expected %0d actual %0d", $time, want.pressure,
                     got.pressure);
            errors++;
          end
          if (got.seg !== want.seg) begin
            $display("%0t: segment expected %0d actual %0d", $time, want.seg, out_segment);
            errors++;
          end
        end
        rx_wait = rx_calm ? 0 : $urandom_range(0, 11);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (rx_wait > 0) begin
      pop <= 1'b0;
      rx_wait--;
    end else begin
      pop <= !rx_hold;
    end
  end

  // long receiver hold-off, started by the flood phase
  bit flood_go = 0;
  initial begin
    rx_hold = 1'b0;
    wait (flood_go);
    rx_hold = 1'b1;
    repeat (FLOOD_HOLD) @(posedge clk);
    rx_hold = 1'b0;
  end

  // drop the offer, then wait for every expected word
  task automatic drain();
    @(negedge clk);
    push = 1'b0;
    wait (level_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ONSET: m_onset = val;
      CFG_RISE:  m_rise  = val;
      CFG_HOLD:  m_hold  = val;
      CFG_FALL:  m_fall  = val;
      CFG_PEAK:  m_peak  = val[PEAK_W-1:0];
      CFG_DEPTH: m_depth = val[DEPTH_W-1:0];
      CFG_RATE:  m_rate  = val[RATE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_word(logic [TIME_BITS-1:0] et, int gap);
    @(negedge clk);
    push = 1'b1;
    in_elapsed_time = et;
    do @(posedge clk); while (full);
    for (int g = 0; g < gap; g++) begin
      @(negedge clk);
      push = 1'b0;
    end
  endtask

  function automatic logic [TIME_BITS-1:0] pick_time();
    longint unsigned span;
    span = m_onset + ((m_rise < MIN_LEN) ? MIN_LEN : m_rise)
         + ((m_hold < MIN_LEN) ? MIN_LEN : m_hold)
         + ((m_fall < MIN_LEN) ? MIN_LEN : m_fall) + 200;
    if ($urandom_range(0, 9) == 0) return TIME_BITS'($urandom());
    if (span > 24'hFFFFFF) span = 24'hFFFFFF;
    return TIME_BITS'($urandom_range(0, int'(span)));
  endfunction

  typedef struct {
    bit                    is_write;
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] val;
    logic [TIME_BITS-1:0]  et;
    bit                    known;
    logic [PEAK_W-1:0]     p;
    seg_t                  s;
  } step_t;

  step_t script [] = '{
    '{0, CFG_ONSET, 0, 24'd0,        1, 17'd0,     SEG_RISE},
    '{0, CFG_ONSET, 0, 24'd500,      1, 17'd32768, SEG_RISE},
    '{0, CFG_ONSET, 0, 24'd1000,     1, 17'd65536, SEG_HOLD},
    '{0, CFG_ONSET, 0, 24'd2000,     1, 17'd65536, SEG_FALL},
    '{0, CFG_ONSET, 0, 24'd2500,     1, 17'd32768, SEG_FALL},
    '{0, CFG_ONSET, 0, 24'd3000,     1, 17'd0,     SEG_DONE},
    '{0, CFG_ONSET, 0, 24'hFFFFFF,   1, 17'd0,     SEG_DONE},
    '{1, CFG_ONSET, 20'd1000, 0,     0, 0, SEG_PRE},
    '{0, CFG_ONSET, 0, 24'd999,      1, 17'd0,     SEG_PRE},
    '{1, CFG_RISE,  20'd0, 0,        0, 0, SEG_PRE},      // short rise acts as minimum
    '{1, CFG_HOLD,  20'd5, 0,        0, 0, SEG_PRE},
    '{1, CFG_FALL,  20'd999, 0,      0, 0, SEG_PRE},
    '{1, CFG_PEAK,  20'h1FFFF, 0,    0, 0, SEG_PRE},      // excess peak clamps
    '{1, CFG_DEPTH, 20'hFFFF, 0,     0, 0, SEG_PRE},
    '{1, CFG_RATE,  20'd0, 0,        0, 0, SEG_PRE},      // slow tremor clamps
    '{1, cfg_idx_t'(3'd7), 20'd77, 0, 0, 0, SEG_PRE},     // bad index, dropped
    '{0, CFG_ONSET, 0, 24'd1500,     0, 0, SEG_PRE},
    '{0, CFG_ONSET, 0, 24'd2250,     0, 0, SEG_PRE},
    '{0, CFG_ONSET, 0, 24'd2750,     0, 0, SEG_PRE},
    '{0, CFG_ONSET, 0, 24'd3500,     0, 0, SEG_PRE},
    '{1, CFG_RATE,  20'hFFFF, 0,     0, 0, SEG_PRE},
    '{0, CFG_ONSET, 0, 24'd2123,     0, 0, SEG_PRE},
    '{0, CFG_ONSET, 0, 24'd2999,     0, 0, SEG_PRE},
    '{0, CFG_ONSET, 0, 24'd3999,     0, 0, SEG_PRE}
  };

  initial begin
    logic [CFG_DATA_W-1:0] v;
    int n;
    for (int k = 0; k <= SINE_DEPTH; k++)
      qsine[k] = taylor_sine((longint'(k) * 64'sd1073741824) / SINE_DEPTH);
    m_onset = 0; m_rise = 1000; m_hold = 1000; m_fall = 1000;
    m_peak = 65536; m_depth = 0; m_rate = 1000;
    rst_n = 1'b0; push = 1'b0; in_elapsed_time = '0;
    cfg_valid = 1'b0; cfg_index = CFG_ONSET; cfg_data = '0;
    row_known = 1'b0; tx_calm = 1'b0; rx_calm = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (script[k]) begin
      if (script[k].is_write) begin
        write_reg(script[k].idx, script[k].val);
      end else begin
        @(negedge clk);
        push = 1'b0;
        row_known = script[k].known;
        row_level.pressure = script[k].p;
        row_level.seg = script[k].s;
        send_word(script[k].et, $urandom_range(0, 3));
      end
    end
    row_known = 1'b0;

    for (int ph = 0; ph < 13; ph++) begin
      for (int r = 0; r <= 7; r++) begin
        case (ph)
          0: v = '1;                                  // all maximal
          1: v = '0;                                  // all minimal, clamps active
          default: begin
            case ($urandom_range(0, 3))
              0: v = CFG_DATA_W'($urandom_range(0, 2000));
              1: v = CFG_DATA_W'($urandom_range(0, 65536));
              default: v = CFG_DATA_W'($urandom());
            endcase
          end
        endcase
        if (r < 7 || ph > 1) write_reg(cfg_idx_t'(r), v);
      end
      tx_calm = (ph % 4 == 3);
      rx_calm = (ph % 5 == 2);
      n = (ph == 6) ? 80 : 55;
      if (ph == 6) flood_go = 1'b1;
      for (int k = 0; k < n; k++)
        send_word(pick_time(), (tx_calm || ph == 6) ? 0 : $urandom_range(0, 11));
      // pause until the pipeline is empty
      if (ph == 9) drain();
    end
    @(negedge clk);
    push = 1'b0;
    drain();
    if (errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: errors");
    $finish;
  end
endmodule
